// ===== design/bst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bst_pkg
// Shared constants and types of the biofilm source term pipeline.
// ----------------------------------------------------------------------------
package bst_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int COMPARTMENTS = 4;

	// restoring divider: one quotient bit per stage
	localparam int NUM_W = 64;
	localparam int DEN_W = 64 - FRAC_BITS;

	// clamp level of every intermediate magnitude
	localparam int CAP_W = 61;
	localparam logic [CAP_W-1:0] CAP = '1;

	localparam logic [DEN_W-1:0] EPS = DEN_W'(((1 << FRAC_BITS) + 500) / 1000);
	localparam logic signed [63:0] ONE = 64'sh1 << FRAC_BITS;

	// divider lanes
	localparam int N_DIV    = 6;
	localparam int DV_ADV_S = 0;
	localparam int DV_ADV_B = 1;
	localparam int DV_UP_B  = 2;
	localparam int DV_UP_F  = 3;
	localparam int DV_RT_B  = 4;
	localparam int DV_RT_F  = 5;

	// multiplier lanes: uptake bulk/film, growth bulk/film
	localparam int N_MUL = 4;

	typedef enum logic [2:0] {
		REG_EXCHANGE_RATE       = 3'd0,
		REG_GROWTH_RATE_BULK    = 3'd1,
		REG_GROWTH_RATE_BIOFILM = 3'd2,
		REG_INVERSE_YIELD       = 3'd3,
		REG_HALF_SAT_BULK       = 3'd4,
		REG_HALF_SAT_BIOFILM    = 3'd5,
		REG_CAPACITY_BULK       = 3'd6,
		REG_CAPACITY_BIOFILM    = 3'd7
	} reg_idx_t;

	// travels alongside the dividers
	typedef struct packed {
		logic signed [63:0] exch;
		logic [31:0]        bb_mag;
		logic               bb_neg;
		logic [31:0]        fb_mag;
		logic               fb_neg;
		logic [N_DIV-1:0]   q_neg;
		logic [N_DIV-1:0]   den_zero;
		logic [N_DIV-1:0]   num_nz;
	} side_t;

	// travels through the multiply stages
	typedef struct packed {
		logic signed [63:0] exch;
		logic signed [63:0] advs;
		logic signed [63:0] advb;
		logic [31:0]        bb_mag;
		logic               bb_neg;
		logic [31:0]        fb_mag;
		logic               fb_neg;
	} late_t;

	typedef struct packed {
		logic             sat;
		logic [CAP_W-1:0] mag;
	} mres_t;

endpackage
`default_nettype wire

// ===== design/bst_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bst_div
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module bst_div import bst_pkg::*; (
	input  wire logic             clk,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [NUM_W-1:0] quo
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] w_s   [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [NUM_W-1:0] w_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign w_in   = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign w_in   = w_s[i-1];
			assign den_in = den_s[i-1];
		end

		// shift in the next numerator bit, subtract when it fits
		assign trial = {rem_in, w_in[NUM_W-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
			w_s[i]   <= {w_in[NUM_W-2:0], ge};
			den_s[i] <= den_in;
		end
	end

	assign quo = w_s[NUM_W-1];

endmodule
`default_nettype wire

// ===== design/biofilm_source_term.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// biofilm_source_term
// Advection, exchange, Monod uptake and logistic growth rates of one pipe cell.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// request   in         start & !busy           eight cell fields
// result    out        done, one cycle         four rates, saturated_flag
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// One request is taken every cycle; busy stays low. A result shows on done
// at the end of the pipeline, whose length is set by the 64 stages of the
// restoring dividers. arst_n clears the valid bits and loads the register
// reset values. Nothing stalls: the receiver takes every result as it comes.
// ----------------------------------------------------------------------------
module biofilm_source_term import bst_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic signed [31:0] conc_bulk_substrate,
	input  wire logic signed [31:0] conc_film_substrate,
	input  wire logic signed [31:0] bulk_biomass,
	input  wire logic signed [31:0] film_biomass,
	input  wire logic signed [31:0] upwind_bulk_substrate,
	input  wire logic signed [31:0] upwind_bulk_biomass,
	input  wire logic signed [31:0] flow_velocity,
	input  wire logic [31:0]        cell_length,
	output logic                    done,
	output logic signed [31:0]      rate_bulk_substrate,
	output logic signed [31:0]      rate_film_substrate,
	output logic signed [31:0]      rate_bulk_biomass,
	output logic signed [31:0]      rate_film_biomass,
	output logic                    saturated_flag
);

	function automatic logic [33:0] mag34(input logic signed [33:0] x);
		return x[33] ? 34'(-x) : x;
	endfunction

	// rescale a split product and clamp it
	function automatic mres_t mul_fin(input logic [63:0] pl, input logic [63:0] ph);
		logic [95:0] full;
		logic [95:0] sh;
		mres_t       r;
		full  = {32'd0, pl} + {ph, 32'd0};
		sh    = full >> FRAC_BITS;
		r.sat = |sh[95:CAP_W];
		r.mag = r.sat ? CAP : sh[CAP_W-1:0];
		return r;
	endfunction

	// configuration registers
	logic [31:0] exchange_rate_q, growth_rate_bulk_q, growth_rate_biofilm_q, inverse_yield_q;
	logic [31:0] half_sat_bulk_q, half_sat_biofilm_q, capacity_bulk_q, capacity_biofilm_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exchange_rate_q       <= '0;
			growth_rate_bulk_q    <= '0;
			growth_rate_biofilm_q <= '0;
			inverse_yield_q       <= 32'(ONE);
			half_sat_bulk_q       <= 32'(ONE);
			half_sat_biofilm_q    <= 32'(ONE);
			capacity_bulk_q       <= 32'(ONE);
			capacity_biofilm_q    <= 32'(ONE);
		end else if (cfg_valid & cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_EXCHANGE_RATE:       exchange_rate_q       <= cfg_data;
				REG_GROWTH_RATE_BULK:    growth_rate_bulk_q    <= cfg_data;
				REG_GROWTH_RATE_BIOFILM: growth_rate_biofilm_q <= cfg_data;
				REG_INVERSE_YIELD:       inverse_yield_q       <= cfg_data;
				REG_HALF_SAT_BULK:       half_sat_bulk_q       <= cfg_data;
				REG_HALF_SAT_BIOFILM:    half_sat_biofilm_q    <= cfg_data;
				REG_CAPACITY_BULK:       capacity_bulk_q       <= cfg_data;
				REG_CAPACITY_BIOFILM:    capacity_biofilm_q    <= cfg_data;
			endcase
		end
	end

	// valid bits
	logic             v_s1, v_s2, v_s3, v_s4;
	logic [NUM_W-1:0] vld_dly_s;
	logic             v_s69, v_s70, v_s71, v_s72, v_s73, v_s74, v_s75, v_s76;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			vld_dly_s <= '0;
			v_s69     <= 1'b0;
			v_s70     <= 1'b0;
			v_s71     <= 1'b0;
			v_s72     <= 1'b0;
			v_s73     <= 1'b0;
			v_s74     <= 1'b0;
			v_s75     <= 1'b0;
			v_s76     <= 1'b0;
		end else begin
			v_s1      <= start & ~busy;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			vld_dly_s <= {vld_dly_s[NUM_W-2:0], v_s4};
			v_s69     <= vld_dly_s[NUM_W-1];
			v_s70     <= v_s69;
			v_s71     <= v_s70;
			v_s72     <= v_s71;
			v_s73     <= v_s72;
			v_s74     <= v_s73;
			v_s75     <= v_s74;
			v_s76     <= v_s75;
		end
	end

	// ---- stage 1: register the request
	logic signed [31:0] sb_s1, sf_s1, bb_s1, fb_s1, usb_s1, ubb_s1, vel_s1;
	logic [31:0]        len_s1;

	always_ff @(posedge clk) begin
		sb_s1  <= conc_bulk_substrate;
		sf_s1  <= conc_film_substrate;
		bb_s1  <= bulk_biomass;
		fb_s1  <= film_biomass;
		usb_s1 <= upwind_bulk_substrate;
		ubb_s1 <= upwind_bulk_biomass;
		vel_s1 <= flow_velocity;
		len_s1 <= cell_length;
	end

	// ---- stage 2: differences, divisors K+s, magnitudes
	logic [31:0] vel_mag_s2, dsu_mag_s2, dbu_mag_s2, dss_mag_s2;
	logic [31:0] sb_mag_s2, sf_mag_s2, bb_mag_s2, fb_mag_s2, len_s2;
	logic        vel_neg_s2, dsu_neg_s2, dbu_neg_s2, dss_neg_s2;
	logic        sb_neg_s2, sf_neg_s2, bb_neg_s2, fb_neg_s2;
	logic [33:0] ks_mag_s2 [2];
	logic        ks_neg_s2 [2];

	always_ff @(posedge clk) begin
		logic signed [33:0] dsu, dbu, dss, ks0, ks1;
		logic [33:0]        m_vel, m_dsu, m_dbu, m_dss, m_sb, m_sf, m_bb, m_fb;
		dsu   = 34'(sb_s1) - 34'(usb_s1);
		dbu   = 34'(bb_s1) - 34'(ubb_s1);
		dss   = 34'(sb_s1) - 34'(sf_s1);
		ks0   = $signed({2'b00, half_sat_bulk_q}) + 34'(sb_s1);
		ks1   = $signed({2'b00, half_sat_biofilm_q}) + 34'(sf_s1);
		m_vel = mag34(34'(vel_s1));
		m_dsu = mag34(dsu);
		m_dbu = mag34(dbu);
		m_dss = mag34(dss);
		m_sb  = mag34(34'(sb_s1));
		m_sf  = mag34(34'(sf_s1));
		m_bb  = mag34(34'(bb_s1));
		m_fb  = mag34(34'(fb_s1));
		vel_mag_s2   <= m_vel[31:0];
		vel_neg_s2   <= vel_s1[31];
		dsu_mag_s2   <= m_dsu[31:0];
		dsu_neg_s2   <= dsu[33];
		dbu_mag_s2   <= m_dbu[31:0];
		dbu_neg_s2   <= dbu[33];
		dss_mag_s2   <= m_dss[31:0];
		dss_neg_s2   <= dss[33];
		sb_mag_s2    <= m_sb[31:0];
		sb_neg_s2    <= sb_s1[31];
		sf_mag_s2    <= m_sf[31:0];
		sf_neg_s2    <= sf_s1[31];
		bb_mag_s2    <= m_bb[31:0];
		bb_neg_s2    <= bb_s1[31];
		fb_mag_s2    <= m_fb[31:0];
		fb_neg_s2    <= fb_s1[31];
		ks_mag_s2[0] <= mag34(ks0);
		ks_neg_s2[0] <= ks0[33];
		ks_mag_s2[1] <= mag34(ks1);
		ks_neg_s2[1] <= ks1[33];
		len_s2       <= len_s1;
	end

	// ---- stage 3: first products
	logic [63:0] nas_s3, nab_s3, exp_s3;
	logic [63:0] nu_s3 [2];
	logic [63:0] cs_s3 [2];
	logic        nas_neg_s3, nab_neg_s3, dss_neg_s3, sb_neg_s3, sf_neg_s3;
	logic [31:0] bb_mag_s3, fb_mag_s3, len_s3;
	logic        bb_neg_s3, fb_neg_s3;
	logic [33:0] ks_mag_s3 [2];
	logic        ks_neg_s3 [2];

	always_ff @(posedge clk) begin
		nas_s3       <= 64'(vel_mag_s2) * 64'(dsu_mag_s2);
		nab_s3       <= 64'(vel_mag_s2) * 64'(dbu_mag_s2);
		exp_s3       <= 64'(exchange_rate_q) * 64'(dss_mag_s2);
		nu_s3[0]     <= 64'(growth_rate_bulk_q) * 64'(sb_mag_s2);
		nu_s3[1]     <= 64'(growth_rate_biofilm_q) * 64'(sf_mag_s2);
		cs_s3[0]     <= 64'(capacity_bulk_q) * 64'(sb_mag_s2);
		cs_s3[1]     <= 64'(capacity_biofilm_q) * 64'(sf_mag_s2);
		nas_neg_s3   <= vel_neg_s2 ^ dsu_neg_s2;
		nab_neg_s3   <= vel_neg_s2 ^ dbu_neg_s2;
		dss_neg_s3   <= dss_neg_s2;
		sb_neg_s3    <= sb_neg_s2;
		sf_neg_s3    <= sf_neg_s2;
		bb_mag_s3    <= bb_mag_s2;
		bb_neg_s3    <= bb_neg_s2;
		fb_mag_s3    <= fb_mag_s2;
		fb_neg_s3    <= fb_neg_s2;
		ks_mag_s3    <= ks_mag_s2;
		ks_neg_s3    <= ks_neg_s2;
		len_s3       <= len_s2;
	end

	// ---- stage 4: exchange term, divisor C*s+EPS, divider operands
	logic [NUM_W-1:0] dnum_c [N_DIV];
	logic [DEN_W-1:0] dden_c [N_DIV];
	side_t            side_c;
	logic [NUM_W-1:0] dnum_s4 [N_DIV];
	logic [DEN_W-1:0] dden_s4 [N_DIV];
	side_t            side_s4;

	always_comb begin
		logic [DEN_W-1:0]   e_sh;
		logic signed [63:0] e_val;
		logic [DEN_W-1:0]   x;
		logic [DEN_W-1:0]   d_mag [2];
		logic               d_neg [2];
		logic               s_neg;
		e_sh  = exp_s3[63:FRAC_BITS];
		e_val = 64'(e_sh);
		for (int k = 0; k < 2; k++) begin
			x     = cs_s3[k][63:FRAC_BITS];
			s_neg = (k == 0) ? sb_neg_s3 : sf_neg_s3;
			// sign of s applied to C*|s|, then EPS added
			if (!s_neg) begin
				d_mag[k] = x + EPS;
				d_neg[k] = 1'b0;
			end else if (x > EPS) begin
				d_mag[k] = x - EPS;
				d_neg[k] = 1'b1;
			end else begin
				d_mag[k] = EPS - x;
				d_neg[k] = 1'b0;
			end
		end
		dnum_c[DV_ADV_S] = nas_s3;
		dden_c[DV_ADV_S] = DEN_W'(len_s3);
		dnum_c[DV_ADV_B] = nab_s3;
		dden_c[DV_ADV_B] = DEN_W'(len_s3);
		dnum_c[DV_UP_B]  = nu_s3[0];
		dden_c[DV_UP_B]  = DEN_W'(ks_mag_s3[0]);
		dnum_c[DV_UP_F]  = nu_s3[1];
		dden_c[DV_UP_F]  = DEN_W'(ks_mag_s3[1]);
		dnum_c[DV_RT_B]  = 64'(bb_mag_s3) << FRAC_BITS;
		dden_c[DV_RT_B]  = d_mag[0];
		dnum_c[DV_RT_F]  = 64'(fb_mag_s3) << FRAC_BITS;
		dden_c[DV_RT_F]  = d_mag[1];
		side_c.exch      = dss_neg_s3 ? -e_val : e_val;
		side_c.bb_mag    = bb_mag_s3;
		side_c.bb_neg    = bb_neg_s3;
		side_c.fb_mag    = fb_mag_s3;
		side_c.fb_neg    = fb_neg_s3;
		side_c.q_neg[DV_ADV_S] = nas_neg_s3;
		side_c.q_neg[DV_ADV_B] = nab_neg_s3;
		side_c.q_neg[DV_UP_B]  = sb_neg_s3 ^ ks_neg_s3[0];
		side_c.q_neg[DV_UP_F]  = sf_neg_s3 ^ ks_neg_s3[1];
		side_c.q_neg[DV_RT_B]  = bb_neg_s3 ^ d_neg[0];
		side_c.q_neg[DV_RT_F]  = fb_neg_s3 ^ d_neg[1];
		for (int k = 0; k < N_DIV; k++) begin
			side_c.den_zero[k] = (dden_c[k] == '0);
			side_c.num_nz[k]   = |dnum_c[k];
		end
	end

	always_ff @(posedge clk) begin
		dnum_s4 <= dnum_c;
		dden_s4 <= dden_c;
		side_s4 <= side_c;
	end

	// ---- stages 5..68: dividers and the matching side line
	logic [NUM_W-1:0] quo [N_DIV];
	side_t            side_dly_s [NUM_W];

	for (genvar k = 0; k < N_DIV; k++) begin : g_div
		bst_div u_div (
			.clk (clk),
			.num (dnum_s4[k]),
			.den (dden_s4[k]),
			.quo (quo[k])
		);
	end

	always_ff @(posedge clk) begin
		side_dly_s[0] <= side_s4;
		for (int i = 1; i < NUM_W; i++) begin
			side_dly_s[i] <= side_dly_s[i-1];
		end
	end

	// ---- stage 69: quotient clamp and zero divisor, 1 - ratio
	late_t              late_s69;
	logic [CAP_W-1:0]   um_mag_s69 [2];
	logic               um_neg_s69 [2];
	logic signed [63:0] om_s69 [2];
	logic               sat_s69;

	always_ff @(posedge clk) begin
		side_t              sd;
		logic [CAP_W-1:0]   qm [N_DIV];
		logic               over;
		logic               sat;
		logic signed [63:0] qv;
		sd  = side_dly_s[NUM_W-1];
		sat = 1'b0;
		for (int k = 0; k < N_DIV; k++) begin
			over = |quo[k][NUM_W-1:CAP_W];
			if (sd.den_zero[k]) begin
				qm[k] = sd.num_nz[k] ? CAP : '0;
			end else begin
				qm[k] = over ? CAP : quo[k][CAP_W-1:0];
			end
			sat = sat | sd.den_zero[k] | over;
		end
		qv = 64'(qm[DV_ADV_S]);
		late_s69.advs   <= sd.q_neg[DV_ADV_S] ? qv : -qv;
		qv = 64'(qm[DV_ADV_B]);
		late_s69.advb   <= sd.q_neg[DV_ADV_B] ? qv : -qv;
		late_s69.exch   <= sd.exch;
		late_s69.bb_mag <= sd.bb_mag;
		late_s69.bb_neg <= sd.bb_neg;
		late_s69.fb_mag <= sd.fb_mag;
		late_s69.fb_neg <= sd.fb_neg;
		um_mag_s69[0]   <= qm[DV_UP_B];
		um_neg_s69[0]   <= sd.q_neg[DV_UP_B];
		um_mag_s69[1]   <= qm[DV_UP_F];
		um_neg_s69[1]   <= sd.q_neg[DV_UP_F];
		qv = 64'(qm[DV_RT_B]);
		om_s69[0]       <= sd.q_neg[DV_RT_B] ? ONE + qv : ONE - qv;
		qv = 64'(qm[DV_RT_F]);
		om_s69[1]       <= sd.q_neg[DV_RT_F] ? ONE + qv : ONE - qv;
		sat_s69         <= sat;
	end

	// ---- stage 70: magnitude of 1 - ratio
	late_t            late_s70;
	logic [63:0]      a_s70 [N_MUL];
	logic             n_s70 [N_MUL];
	logic             sat_s70;

	always_ff @(posedge clk) begin
		late_s70 <= late_s69;
		a_s70[0] <= 64'(um_mag_s69[0]);
		n_s70[0] <= um_neg_s69[0];
		a_s70[1] <= 64'(um_mag_s69[1]);
		n_s70[1] <= um_neg_s69[1];
		for (int k = 0; k < 2; k++) begin
			a_s70[k+2] <= om_s69[k][63] ? 64'(-om_s69[k]) : 64'(om_s69[k]);
			n_s70[k+2] <= om_s69[k][63];
		end
		sat_s70 <= sat_s69;
	end

	// ---- stage 71: partial products by inverse yield and growth rate
	late_t       late_s71;
	logic [63:0] pl_s71 [N_MUL];
	logic [63:0] ph_s71 [N_MUL];
	logic        n_s71  [N_MUL];
	logic        sat_s71;

	always_ff @(posedge clk) begin
		logic [31:0] b [N_MUL];
		b[0] = inverse_yield_q;
		b[1] = inverse_yield_q;
		b[2] = growth_rate_bulk_q;
		b[3] = growth_rate_biofilm_q;
		for (int j = 0; j < N_MUL; j++) begin
			pl_s71[j] <= 64'(a_s70[j][31:0]) * 64'(b[j]);
			ph_s71[j] <= 64'(a_s70[j][63:32]) * 64'(b[j]);
			n_s71[j]  <= n_s70[j];
		end
		late_s71 <= late_s70;
		sat_s71  <= sat_s70;
	end

	// ---- stage 72: combine, rescale, clamp
	late_t            late_s72;
	logic [CAP_W-1:0] m_s72 [N_MUL];
	logic             n_s72 [N_MUL];
	logic             sat_s72;

	always_ff @(posedge clk) begin
		mres_t mr;
		logic  sat;
		sat = sat_s71;
		for (int j = 0; j < N_MUL; j++) begin
			mr       = mul_fin(pl_s71[j], ph_s71[j]);
			m_s72[j] <= mr.mag;
			n_s72[j] <= n_s71[j];
			sat      = sat | mr.sat;
		end
		late_s72 <= late_s71;
		sat_s72  <= sat;
	end

	// ---- stage 73: partial products by biomass
	late_t       late_s73;
	logic [63:0] pl_s73 [N_MUL];
	logic [63:0] ph_s73 [N_MUL];
	logic        n_s73  [N_MUL];
	logic        sat_s73;

	always_ff @(posedge clk) begin
		logic [31:0] b;
		logic        bn;
		for (int j = 0; j < N_MUL; j++) begin
			// even lanes are bulk, odd lanes film
			b  = j[0] ? late_s72.fb_mag : late_s72.bb_mag;
			bn = j[0] ? late_s72.fb_neg : late_s72.bb_neg;
			pl_s73[j] <= 64'(m_s72[j][31:0]) * 64'(b);
			ph_s73[j] <= 64'(m_s72[j][CAP_W-1:32]) * 64'(b);
			n_s73[j]  <= n_s72[j] ^ bn;
		end
		late_s73 <= late_s72;
		sat_s73  <= sat_s72;
	end

	// ---- stage 74: combine, rescale, clamp, apply sign
	late_t              late_s74;
	logic signed [63:0] val_s74 [N_MUL];
	logic               sat_s74;

	always_ff @(posedge clk) begin
		mres_t              mr;
		logic               sat;
		logic signed [63:0] mv;
		sat = sat_s73;
		for (int j = 0; j < N_MUL; j++) begin
			mr         = mul_fin(pl_s73[j], ph_s73[j]);
			mv         = 64'(mr.mag);
			val_s74[j] <= n_s73[j] ? -mv : mv;
			sat        = sat | mr.sat;
		end
		late_s74 <= late_s73;
		sat_s74  <= sat;
	end

	// ---- stage 75: sum the terms
	logic signed [63:0] r_s75 [COMPARTMENTS];
	logic               sat_s75;

	always_ff @(posedge clk) begin
		r_s75[0] <= late_s74.advs - late_s74.exch - val_s74[0];
		r_s75[1] <= late_s74.exch - val_s74[1];
		r_s75[2] <= late_s74.advb + val_s74[2];
		r_s75[3] <= val_s74[3];
		sat_s75  <= sat_s74;
	end

	// ---- stage 76: saturate to 32 bits
	logic signed [31:0] out_s76 [COMPARTMENTS];
	logic               sat_s76;

	always_ff @(posedge clk) begin
		logic sat;
		sat = sat_s75;
		for (int j = 0; j < COMPARTMENTS; j++) begin
			if (r_s75[j] > 64'sh7FFF_FFFF) begin
				out_s76[j] <= 32'sh7FFF_FFFF;
				sat        = 1'b1;
			end else if (r_s75[j] < -64'sh8000_0000) begin
				out_s76[j] <= 32'sh8000_0000;
				sat        = 1'b1;
			end else begin
				out_s76[j] <= r_s75[j][31:0];
			end
		end
		sat_s76 <= sat;
	end

	assign done                = v_s76;
	assign rate_bulk_substrate = out_s76[0];
	assign rate_film_substrate = out_s76[1];
	assign rate_bulk_biomass   = out_s76[2];
	assign rate_film_biomass   = out_s76[3];
	assign saturated_flag      = sat_s76;

endmodule
`default_nettype wire
